/* src/rhd_pkg.sv */
// ----------------------------------------------------------------------------
// rhd_pkg
// Shared types and constants of the Robin Hood hash dictionary.
// ----------------------------------------------------------------------------
`default_nettype none
package rhd_pkg;

  localparam int TableSlots = 256;
  localparam int SlotBits   = $clog2(TableSlots);
  localparam int DistBits   = SlotBits + 1;
  localparam int DescBits   = 16;
  localparam int KeyBits    = 64;
  localparam int SizeBits   = 40;
  localparam int RateBits   = 32;
  localparam int CountBits  = SlotBits + 1;
  localparam int RecBits    = KeyBits + DescBits + SizeBits + RateBits;
  localparam int QueueDepth = 2;
  localparam logic [31:0] HashMult = 32'd2654435761;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_RENAME = 2'd2,
    CMD_LOOKUP = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_NEW           = 3'd0,
    ST_DONE          = 3'd1,
    ST_ABSENT        = 3'd2,
    ST_FULL          = 3'd3,
    ST_TARGET_EXISTS = 3'd4,
    ST_FOUND         = 3'd5
  } status_t;

  // A request after the front end: command, both identifiers with their
  // home slots, and the record to store.
  typedef struct packed {
    cmd_t                  cmd;
    logic [KeyBits-1:0]    key_id;
    logic [SlotBits-1:0]   key_home;
    logic [KeyBits-1:0]    target_id;
    logic [SlotBits-1:0]   target_home;
    logic                  same_id;
    logic [DescBits-1:0]   descriptor;
    logic [SizeBits-1:0]   byte_size;
    logic [RateBits-1:0]   rate;
  } req_t;

  typedef struct packed {
    status_t               status;
    logic                  has_descriptor;
    logic [DescBits-1:0]   descriptor;
    logic [SizeBits-1:0]   size;
    logic [RateBits-1:0]   rate;
  } rsp_t;

  typedef struct packed {
    logic [KeyBits-1:0]  key;
    logic [DescBits-1:0] descriptor;
    logic [SizeBits-1:0] size;
    logic [RateBits-1:0] rate;
  } rec_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_FIND_RD,
    BK_FIND_CHK,
    BK_TGT_RD,
    BK_TGT_CHK,
    BK_DEL_RD,
    BK_DEL_CHK,
    BK_PUT_RD,
    BK_PUT_CHK,
    BK_DONE
  } bk_state_t;

endpackage
`default_nettype wire

/* src/rhd_ram.sv */
// ----------------------------------------------------------------------------
// rhd_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module rhd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(Depth)-1:0] wr_addr,
  input  wire logic [Width-1:0]         wr_data,
  input  wire logic [$clog2(Depth)-1:0] rd_addr,
  output      logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

/* src/rhd_front.sv */
// ----------------------------------------------------------------------------
// rhd_front
// Takes requests, hashes both identifiers and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module rhd_front
  import rhd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  output      logic                full,
  input  wire logic [1:0]          cmd,
  input  wire logic [KeyBits-1:0]  key_id,
  input  wire logic [KeyBits-1:0]  target_id,
  input  wire logic [DescBits-1:0] descriptor,
  input  wire logic [SizeBits-1:0] byte_size,
  input  wire logic [RateBits-1:0] rate,
  output      logic                req_valid,
  output      req_t                req,
  input  wire logic                req_take
);

  localparam int PtrBits = $clog2(QueueDepth);

  req_t               q_r [QueueDepth];
  logic [PtrBits-1:0] wp_r, rp_r;
  logic [PtrBits:0]   cnt_r;
  logic [31:0]        kprod, tprod;
  req_t               nreq;
  logic               do_push, do_pop;

  // Only the low slot bits of the product are needed, so the low 32 bits of
  // the identifier suffice.
  assign kprod = key_id[31:0] * HashMult;
  assign tprod = target_id[31:0] * HashMult;

  always_comb begin
    nreq.cmd         = cmd_t'(cmd);
    nreq.key_id      = key_id;
    nreq.key_home    = kprod[SlotBits-1:0];
    nreq.target_id   = target_id;
    nreq.target_home = tprod[SlotBits-1:0];
    nreq.same_id     = (key_id == target_id);
    nreq.descriptor  = descriptor;
    nreq.byte_size   = byte_size;
    nreq.rate        = rate;
  end

  assign full      = (cnt_r == (PtrBits + 1)'(QueueDepth));
  assign req_valid = (cnt_r != '0);
  assign req       = q_r[rp_r];
  assign do_push   = push && !full;
  assign do_pop    = req_take && req_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wp_r] <= nreq;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (PtrBits + 1)'(do_push) - (PtrBits + 1)'(do_pop);
    end
  end

endmodule
`default_nettype wire

/* src/rhd_back.sv */
// ----------------------------------------------------------------------------
// rhd_back
// Probe sequencer: lookup, Robin Hood placement and backward-shift deletion
// over the slot memories, each slot read registered and then compared.
// ----------------------------------------------------------------------------
`default_nettype none
module rhd_back
  import rhd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic req_valid,
  input  wire req_t req,
  output      logic req_take,
  output      logic rsp_valid,
  output      rsp_t rsp,
  input  wire logic rsp_take
);

  bk_state_t st_r, st_nxt;

  // Occupied bits live in flip-flops so reset clears them; probe distances
  // sit in a RAM of their own and are only trusted in occupied slots.
  logic                occ_r  [TableSlots];
  logic [CountBits-1:0] count_r, count_nxt;

  req_t                 cur_r, cur_nxt;
  logic [SlotBits-1:0]  p_r, p_nxt, hit_r, hit_nxt;
  logic [DistBits-1:0]  d_r, d_nxt;
  rec_t                 carry_r, carry_nxt;
  rsp_t                 rsp_r, rsp_nxt;
  rsp_t                 res_r, res_nxt;
  logic                 rv_r, rv_nxt;

  logic                 wr_en;
  logic [SlotBits-1:0]  wr_addr, rd_addr;
  rec_t                 wr_rec, rd_rec;
  logic                 m_wr;
  logic [SlotBits-1:0]  m_addr;
  logic                 m_occ;
  logic [DistBits-1:0]  m_dist;
  logic [DistBits-1:0]  rd_dist;

  logic [SlotBits-1:0]  p_inc;
  logic                 cur_occ;
  logic [DistBits-1:0]  cur_dist;

  rhd_ram #(.Width(RecBits), .Depth(TableSlots)) u_rec (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_rec),
    .rd_addr (rd_addr),
    .rd_data (rd_rec)
  );

  rhd_ram #(.Width(DistBits), .Depth(TableSlots)) u_dist (
    .clk     (clk),
    .wr_en   (m_wr),
    .wr_addr (m_addr),
    .wr_data (m_dist),
    .rd_addr (rd_addr),
    .rd_data (rd_dist)
  );

  assign p_inc    = p_r + 1'b1;
  assign cur_occ  = occ_r[p_r];
  assign cur_dist = rd_dist;
  assign rsp_valid = rv_r;
  assign rsp       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= BK_IDLE;
      count_r <= '0;
      rv_r    <= 1'b0;
      for (int i = 0; i < TableSlots; i++) begin
        occ_r[i] <= 1'b0;
      end
    end else begin
      st_r    <= st_nxt;
      count_r <= count_nxt;
      rv_r    <= rv_nxt;
      if (m_wr) begin
        occ_r[m_addr] <= m_occ;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    p_r     <= p_nxt;
    hit_r   <= hit_nxt;
    d_r     <= d_nxt;
    carry_r <= carry_nxt;
    rsp_r   <= rsp_nxt;
    res_r   <= res_nxt;
  end

  always_comb begin
    st_nxt    = st_r;
    count_nxt = count_r;
    cur_nxt   = cur_r;
    p_nxt     = p_r;
    hit_nxt   = hit_r;
    d_nxt     = d_r;
    carry_nxt = carry_r;
    rsp_nxt   = rsp_r;
    res_nxt   = res_r;
    rv_nxt    = rv_r;
    req_take  = 1'b0;
    rd_addr   = p_r;
    wr_en     = 1'b0;
    wr_addr   = p_r;
    wr_rec    = carry_r;
    m_wr      = 1'b0;
    m_addr    = p_r;
    m_occ     = 1'b0;
    m_dist    = '0;

    if (rv_r && rsp_take) begin
      rv_nxt = 1'b0;
    end

    case (st_r)
      BK_IDLE: begin
        if (req_valid) begin
          req_take = 1'b1;
          cur_nxt  = req;
          p_nxt    = req.key_home;
          d_nxt    = '0;
          rsp_nxt  = '{status: ST_ABSENT, default: '0};
          st_nxt   = BK_FIND_RD;
        end
      end
      BK_FIND_RD: begin
        st_nxt = BK_FIND_CHK;
      end
      BK_FIND_CHK: begin
        if (!cur_occ || cur_dist < d_r || d_r == DistBits'(TableSlots)) begin
          // Key absent.
          if (cur_r.cmd == CMD_INSERT) begin
            if (count_r == CountBits'(TableSlots)) begin
              rsp_nxt.status = ST_FULL;
              st_nxt = BK_DONE;
            end else begin
              rsp_nxt.status = ST_NEW;
              carry_nxt = '{key: cur_r.key_id, descriptor: cur_r.descriptor,
                            size: cur_r.byte_size, rate: cur_r.rate};
              p_nxt  = cur_r.key_home;
              d_nxt  = '0;
              st_nxt = BK_PUT_RD;
            end
          end else begin
            st_nxt = BK_DONE;
          end
        end else if (rd_rec.key == cur_r.key_id) begin
          hit_nxt = p_r;
          case (cur_r.cmd)
            CMD_INSERT: begin
              rsp_nxt.status = ST_DONE;
              rsp_nxt.has_descriptor = 1'b1;
              rsp_nxt.descriptor = rd_rec.descriptor;
              wr_en  = 1'b1;
              wr_rec = '{key: rd_rec.key, descriptor: cur_r.descriptor,
                         size: cur_r.byte_size, rate: cur_r.rate};
              st_nxt = BK_DONE;
            end
            CMD_REMOVE: begin
              rsp_nxt.status = ST_DONE;
              rsp_nxt.has_descriptor = 1'b1;
              rsp_nxt.descriptor = rd_rec.descriptor;
              carry_nxt = rd_rec;
              p_nxt  = p_inc;
              st_nxt = BK_DEL_RD;
            end
            CMD_RENAME: begin
              rsp_nxt.status = ST_DONE;
              carry_nxt = rd_rec;
              if (cur_r.same_id) begin
                st_nxt = BK_DONE;
              end else begin
                p_nxt  = cur_r.target_home;
                d_nxt  = '0;
                st_nxt = BK_TGT_RD;
              end
            end
            default: begin
              rsp_nxt.status = ST_FOUND;
              rsp_nxt.has_descriptor = 1'b1;
              rsp_nxt.descriptor = rd_rec.descriptor;
              rsp_nxt.size = rd_rec.size;
              rsp_nxt.rate = rd_rec.rate;
              st_nxt = BK_DONE;
            end
          endcase
        end else begin
          p_nxt  = p_inc;
          d_nxt  = d_r + 1'b1;
          st_nxt = BK_FIND_RD;
        end
      end
      BK_TGT_RD: begin
        st_nxt = BK_TGT_CHK;
      end
      BK_TGT_CHK: begin
        if (!cur_occ || cur_dist < d_r || d_r == DistBits'(TableSlots)) begin
          // Target free: delete the source, then place under the new key.
          carry_nxt.key = cur_r.target_id;
          p_nxt  = hit_r + 1'b1;
          st_nxt = BK_DEL_RD;
        end else if (rd_rec.key == cur_r.target_id) begin
          rsp_nxt.status = ST_TARGET_EXISTS;
          st_nxt = BK_DONE;
        end else begin
          p_nxt  = p_inc;
          d_nxt  = d_r + 1'b1;
          st_nxt = BK_TGT_RD;
        end
      end
      BK_DEL_RD: begin
        st_nxt = BK_DEL_CHK;
      end
      BK_DEL_CHK: begin
        // p_r is the successor, hit_r the hole.
        if (!cur_occ || cur_dist == '0) begin
          m_wr   = 1'b1;
          m_addr = hit_r;
          m_occ  = 1'b0;
          count_nxt = count_r - 1'b1;
          if (cur_r.cmd == CMD_RENAME) begin
            p_nxt  = cur_r.target_home;
            d_nxt  = '0;
            st_nxt = BK_PUT_RD;
          end else begin
            st_nxt = BK_DONE;
          end
        end else begin
          wr_en   = 1'b1;
          wr_addr = hit_r;
          wr_rec  = rd_rec;
          m_wr    = 1'b1;
          m_addr  = hit_r;
          m_occ   = 1'b1;
          m_dist  = cur_dist - 1'b1;
          hit_nxt = p_r;
          p_nxt   = p_inc;
          st_nxt  = BK_DEL_RD;
        end
      end
      BK_PUT_RD: begin
        st_nxt = BK_PUT_CHK;
      end
      BK_PUT_CHK: begin
        if (!cur_occ) begin
          wr_en  = 1'b1;
          m_wr   = 1'b1;
          m_occ  = 1'b1;
          m_dist = d_r;
          count_nxt = count_r + 1'b1;
          st_nxt = BK_DONE;
        end else begin
          if (cur_dist < d_r) begin
            // Richer resident yields its slot and becomes the carried entry.
            wr_en     = 1'b1;
            m_wr      = 1'b1;
            m_occ     = 1'b1;
            m_dist    = d_r;
            carry_nxt = rd_rec;
            d_nxt     = cur_dist + 1'b1;
          end else begin
            d_nxt = d_r + 1'b1;
          end
          p_nxt  = p_inc;
          st_nxt = BK_PUT_RD;
        end
      end
      BK_DONE: begin
        // The finished result moves to the output register once it is free.
        if (!rv_r || rsp_take) begin
          rv_nxt  = 1'b1;
          res_nxt = rsp_r;
          st_nxt  = BK_IDLE;
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* src/robin_hood_hash_dictionary_top.sv */
// ----------------------------------------------------------------------------
// robin_hood_hash_dictionary_top
// Map from 64-bit identifiers to descriptor, size and bitrate records.
// ----------------------------------------------------------------------------
// Each request probes the table from its identifier's home slot, one slot
// at a time (registered read of the record memory, then compare). A lookup
// or update walks one probe run; insert of a new key, remove and rename add
// further linear runs for the placement, the backward shift or the target
// search. A two-entry queue in front lets requests arrive while one is
// being worked; the result waits in an output register. The table is
// empty right after reset, with no clearing pass.
`default_nettype none
module robin_hood_hash_dictionary_top
  import rhd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  output      logic                full,
  input  wire logic [1:0]          in_cmd,
  input  wire logic [KeyBits-1:0]  in_key_id,
  input  wire logic [KeyBits-1:0]  in_target_id,
  input  wire logic [DescBits-1:0] in_descriptor,
  input  wire logic [SizeBits-1:0] in_byte_size,
  input  wire logic [RateBits-1:0] in_rate,
  output      logic                empty,
  input  wire logic                pop,
  output      logic [2:0]          out_status,
  output      logic                out_has_descriptor,
  output      logic [DescBits-1:0] out_out_descriptor,
  output      logic [SizeBits-1:0] out_out_size,
  output      logic [RateBits-1:0] out_out_rate
);

  logic req_valid, req_take, rsp_valid;
  req_t req;
  rsp_t rsp;

  rhd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .cmd        (in_cmd),
    .key_id     (in_key_id),
    .target_id  (in_target_id),
    .descriptor (in_descriptor),
    .byte_size  (in_byte_size),
    .rate       (in_rate),
    .req_valid  (req_valid),
    .req        (req),
    .req_take   (req_take)
  );

  rhd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req       (req),
    .req_take  (req_take),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .rsp_take  (pop)
  );

  assign empty              = !rsp_valid;
  assign out_status         = rsp.status;
  assign out_has_descriptor = rsp.has_descriptor;
  assign out_out_descriptor = rsp.descriptor;
  assign out_out_size       = rsp.size;
  assign out_out_rate       = rsp.rate;

endmodule
`default_nettype wire

/* src/rhd_checker.sv */
// ----------------------------------------------------------------------------
// rhd_port_checks
// Port-level checks of the dictionary's request and result queues.
// ----------------------------------------------------------------------------
`default_nettype none
module rhd_port_checks
  import rhd_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                full,
  input wire logic                empty,
  input wire logic                pop,
  input wire logic [2:0]          out_status,
  input wire logic                out_has_descriptor,
  input wire logic [SizeBits-1:0] out_out_size
);

  // A result held while not taken must keep its status.
  assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> $stable(out_status))
    else $error("result changed while waiting");

  assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_status != ST_FOUND |-> out_out_size == '0)
    else $error("size shown on a result other than found");

  assert property (@(posedge clk) disable iff (!rst_n)
    !empty && (out_status == ST_NEW || out_status == ST_ABSENT ||
               out_status == ST_FULL || out_status == ST_TARGET_EXISTS)
    |-> !out_has_descriptor)
    else $error("descriptor flagged on a result without one");

  assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("queues not empty after reset");

endmodule

bind robin_hood_hash_dictionary_top rhd_port_checks u_rhd_port_checks (
  .clk                (clk),
  .rst_n              (rst_n),
  .full               (full),
  .empty              (empty),
  .pop                (pop),
  .out_status         (out_status),
  .out_has_descriptor (out_has_descriptor),
  .out_out_size       (out_out_size)
);
`default_nettype wire

/* tb/rhd_checker.sv */
// ----------------------------------------------------------------------------
// rhd_checker
// Watches both channels of the Robin Hood hash dictionary, keeps its own
// copy of the table, predicts each result and compares it with the block.
// ----------------------------------------------------------------------------
module rhd_checker
  import rhd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic                full,
  input  logic [1:0]          in_cmd,
  input  logic [KeyBits-1:0]  in_key_id,
  input  logic [KeyBits-1:0]  in_target_id,
  input  logic [DescBits-1:0] in_descriptor,
  input  logic [SizeBits-1:0] in_byte_size,
  input  logic [RateBits-1:0] in_rate,
  input  logic                empty,
  input  logic                pop,
  input  logic [2:0]          out_status,
  input  logic                out_has_descriptor,
  input  logic [DescBits-1:0] out_out_descriptor,
  input  logic [SizeBits-1:0] out_out_size,
  input  logic [RateBits-1:0] out_out_rate,
  output int                  fail_count,
  output int                  pending,
  output int                  checked
);

  rec_t tbl_rec  [TableSlots];
  bit   tbl_used [TableSlots];
  int   tbl_dist [TableSlots];
  int   live_entries;
  rsp_t awaited_rsp[$];

  function automatic int home_of(logic [KeyBits-1:0] key);
    logic [KeyBits-1:0] prod;
    prod = key * 64'd2654435761;
    return int'(prod % TableSlots);
  endfunction

  function automatic int slot_after(int p);
    return (p + 1 >= TableSlots) ? 0 : p + 1;
  endfunction

  // Returns the slot holding key, or -1.
  function automatic int locate(logic [KeyBits-1:0] key);
    int p;
    p = home_of(key);
    for (int d = 0; d < TableSlots; d++) begin
      if (!tbl_used[p] || tbl_dist[p] < d) return -1;
      if (tbl_rec[p].key == key) return p;
      p = slot_after(p);
    end
    return -1;
  endfunction

  function automatic void place_record(rec_t r);
    int   p;
    int   d;
    rec_t tr;
    int   td;
    p = home_of(r.key);
    d = 0;
    for (int n = 0; n < TableSlots; n++) begin
      if (!tbl_used[p]) begin
        tbl_rec[p]  = r;
        tbl_used[p] = 1'b1;
        tbl_dist[p] = d;
        live_entries++;
        return;
      end
      // The richer resident gives up its slot and is carried on.
      if (tbl_dist[p] < d) begin
        tr = tbl_rec[p];
        td = tbl_dist[p];
        tbl_rec[p]  = r;
        tbl_dist[p] = d;
        r = tr;
        d = td;
      end
      p = slot_after(p);
      d++;
    end
  endfunction

  function automatic void shift_out(int p);
    int q;
    for (int n = 0; n < TableSlots; n++) begin
      q = slot_after(p);
      if (!tbl_used[q] || tbl_dist[q] == 0) begin
        tbl_used[p] = 1'b0;
        break;
      end
      tbl_rec[p]  = tbl_rec[q];
      tbl_dist[p] = tbl_dist[q] - 1;
      p = q;
    end
    if (live_entries > 0) live_entries--;
  endfunction

  function automatic rsp_t apply_request(cmd_t cmd, logic [KeyBits-1:0] key,
                                         logic [KeyBits-1:0] target, rec_t data);
    rsp_t r;
    int   p;
    rec_t moved;
    r = '0;
    r.status = ST_ABSENT;
    p = locate(key);
    case (cmd)
      CMD_INSERT: begin
        if (p >= 0) begin
          r.status = ST_DONE;
          r.has_descriptor = 1'b1;
          r.descriptor = tbl_rec[p].descriptor;
          tbl_rec[p].descriptor = data.descriptor;
          tbl_rec[p].size = data.size;
          tbl_rec[p].rate = data.rate;
        end else if (live_entries >= TableSlots) begin
          r.status = ST_FULL;
        end else begin
          place_record(data);
          r.status = ST_NEW;
        end
      end
      CMD_REMOVE: begin
        if (p >= 0) begin
          r.status = ST_DONE;
          r.has_descriptor = 1'b1;
          r.descriptor = tbl_rec[p].descriptor;
          shift_out(p);
        end
      end
      CMD_RENAME: begin
        if (p >= 0) begin
          if (target == key) begin
            r.status = ST_DONE;
          end else if (locate(target) >= 0) begin
            r.status = ST_TARGET_EXISTS;
          end else begin
            moved = tbl_rec[p];
            moved.key = target;
            shift_out(p);
            place_record(moved);
            r.status = ST_DONE;
          end
        end
      end
      default: begin
        if (p >= 0) begin
          r.status = ST_FOUND;
          r.has_descriptor = 1'b1;
          r.descriptor = tbl_rec[p].descriptor;
          r.size = tbl_rec[p].size;
          r.rate = tbl_rec[p].rate;
        end
      end
    endcase
    return r;
  endfunction

  assign pending = awaited_rsp.size();

  always @(posedge clk) begin
    rec_t data;
    rsp_t want;
    if (!rst_n) begin
      for (int i = 0; i < TableSlots; i++) tbl_used[i] = 1'b0;
      live_entries = 0;
      awaited_rsp.delete();
      fail_count = 0;
      checked = 0;
    end else begin
      if (push && !full) begin
        data.key = in_key_id;
        data.descriptor = in_descriptor;
        data.size = in_byte_size;
        data.rate = in_rate;
        awaited_rsp.push_back(apply_request(cmd_t'(in_cmd), in_key_id, in_target_id, data));
      end
      if (pop && !empty) begin
        checked++;
        if (awaited_rsp.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          want = awaited_rsp.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            fail_count++;
          end
          if (out_has_descriptor !== want.has_descriptor) begin
            $error("has_descriptor: expected %0d, got %0d", want.has_descriptor,
                   out_has_descriptor);
            fail_count++;
          end
          if (out_out_descriptor !== want.descriptor) begin
            $error("out_descriptor: expected %h, got %h", want.descriptor,
                   out_out_descriptor);
            fail_count++;
          end
          if (out_out_size !== want.size) begin
            $error("out_size: expected %h, got %h", want.size, out_out_size);
            fail_count++;
          end
          if (out_out_rate !== want.rate) begin
            $error("out_rate: expected %h, got %h", want.rate, out_out_rate);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stimulus for the Robin Hood hash dictionary: directed corner requests,
// random traffic over clustered identifiers, then a fill to capacity.
// ----------------------------------------------------------------------------
module tb;
  import rhd_pkg::*;

  logic                clk;
  logic                rst_n;
  logic                push;
  logic                full;
  logic [1:0]          in_cmd;
  logic [KeyBits-1:0]  in_key_id;
  logic [KeyBits-1:0]  in_target_id;
  logic [DescBits-1:0] in_descriptor;
  logic [SizeBits-1:0] in_byte_size;
  logic [RateBits-1:0] in_rate;
  logic                empty;
  logic                pop;
  logic [2:0]          out_status;
  logic                out_has_descriptor;
  logic [DescBits-1:0] out_out_descriptor;
  logic [SizeBits-1:0] out_out_size;
  logic [RateBits-1:0] out_out_rate;
  int                  fail_count;
  int                  pending;
  int                  checked;

  bit                  steady;
  int                  sent;
  logic [KeyBits-1:0]  key_pool [48];
  logic [KeyBits-1:0]  fill_keys[$];

  robin_hood_hash_dictionary_top uut (.*);

  rhd_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("** robin_hood_hash_dictionary_top: FAILED **");
    $finish;
  end

  function automatic logic [KeyBits-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  // Receiver: random pops, with one long hold-off so the queue backs up.
  initial begin
    int hold;
    pop = 1'b0;
    hold = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (checked == 30 && hold == 0) hold = 300;
      if (hold > 1) begin
        pop = 1'b0;
        hold--;
      end else begin
        pop = steady || ($urandom_range(0, 99) >= 38);
      end
    end
  end

  task automatic send(cmd_t cmd, logic [KeyBits-1:0] key, logic [KeyBits-1:0] target,
                      logic [DescBits-1:0] desc, logic [SizeBits-1:0] size,
                      logic [RateBits-1:0] rate);
    while (!steady && $urandom_range(0, 99) < 38) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1;
    in_cmd = cmd;
    in_key_id = key;
    in_target_id = target;
    in_descriptor = desc;
    in_byte_size = size;
    in_rate = rate;
    do @(posedge clk); while (full);
    @(negedge clk);
    push = 1'b0;
    sent++;
  endtask

  task automatic send_rand(cmd_t cmd, logic [KeyBits-1:0] key, logic [KeyBits-1:0] target);
    send(cmd, key, target, DescBits'($urandom), SizeBits'({$urandom, $urandom}), $urandom);
  endtask

  initial begin
    logic [KeyBits-1:0] ka;
    logic [KeyBits-1:0] kb;
    logic [KeyBits-1:0] kt;
    int                 pick;
    int                 wait_cycles;
    rst_n = 1'b0;
    push = 1'b0;
    in_cmd = CMD_INSERT;
    in_key_id = '0;
    in_target_id = '0;
    in_descriptor = '0;
    in_byte_size = '0;
    in_rate = '0;
    steady = 1'b0;
    sent = 0;
    for (int i = 0; i < 48; i++) begin
      // Identifiers sharing a low byte share a home slot, so this clusters.
      ka = rand_key();
      key_pool[i] = {ka[KeyBits-1:8], 8'($urandom_range(0, 5))};
    end
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    ka = 64'h0;
    kb = '1;
    send(CMD_LOOKUP, ka, kb, '1, '1, '1);
    send(CMD_REMOVE, ka, kb, '0, '0, '0);
    send(CMD_RENAME, ka, kb, '0, '0, '0);
    send(CMD_INSERT, ka, kb, '0, '0, '0);
    send(CMD_INSERT, kb, ka, '1, '1, '1);
    send(CMD_LOOKUP, kb, ka, '0, '0, '0);
    send(CMD_INSERT, ka, '1, 16'h5a5a, 40'h12_3456_789a, 32'hdead_beef);
    send(CMD_LOOKUP, ka, '0, '0, '0, '0);
    send(CMD_RENAME, ka, ka, '0, '0, '0);
    send(CMD_RENAME, ka, kb, '0, '0, '0);
    send(CMD_RENAME, ka, 64'h100, '0, '0, '0);
    send(CMD_LOOKUP, 64'h100, '0, '0, '0, '0);
    send(CMD_LOOKUP, ka, '0, '0, '0, '0);
    // Same home slot for all three, then pull the middle one out.
    send_rand(CMD_INSERT, 64'h200, '0);
    send_rand(CMD_INSERT, 64'h300, '0);
    send(CMD_REMOVE, 64'h200, '0, '0, '0, '0);
    send(CMD_LOOKUP, 64'h300, '0, '0, '0, '0);
    send(CMD_LOOKUP, 64'h100, '0, '0, '0, '0);
    send(CMD_RENAME, 64'h300, 64'h200, '0, '0, '0);
    send(CMD_REMOVE, 64'h200, '0, '0, '0, '0);
    send(CMD_REMOVE, kb, '0, '0, '0, '0);

    for (int i = 0; i < 140; i++) begin
      steady = (i >= 60 && i < 100);
      ka = key_pool[$urandom_range(0, 47)];
      kt = ($urandom_range(0, 99) < 70) ? key_pool[$urandom_range(0, 47)] : rand_key();
      pick = $urandom_range(0, 99);
      if (pick < 35) send_rand(CMD_INSERT, ka, rand_key());
      else if (pick < 55) send_rand(CMD_REMOVE, ka, rand_key());
      else if (pick < 70) send_rand(CMD_RENAME, ka, kt);
      else send_rand(CMD_LOOKUP, ka, rand_key());
    end
    steady = 1'b0;

    // Fill to capacity; the later inserts must come back as table full.
    for (int i = 0; i < 262; i++) begin
      kt = rand_key();
      fill_keys.push_back(kt);
      send_rand(CMD_INSERT, kt, rand_key());
    end
    for (int i = 0; i < 30; i++) begin
      ka = fill_keys[$urandom_range(0, fill_keys.size() - 1)];
      pick = $urandom_range(0, 3);
      if (pick == 0) send_rand(CMD_LOOKUP, ka, '0);
      else if (pick == 1) send_rand(CMD_REMOVE, ka, '0);
      else if (pick == 2) send_rand(CMD_RENAME, ka, rand_key());
      else send_rand(CMD_INSERT, rand_key(), '0);
    end

    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 200000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (50) @(negedge clk);
    $display("Sent %0d requests (directed corners, clustered random, fill to capacity);",
             sent);
    $display("checked %0d results with %0d requests left unanswered.", checked, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("** robin_hood_hash_dictionary_top: PASSED **");
    end else begin
      $display("** robin_hood_hash_dictionary_top: FAILED **");
    end
    $finish;
  end

endmodule
